// File: hw/rtl/les_pkg.sv
// les_pkg: shared types and constants for the led effect sequencer
// no dependencies; imported by les_if, les_step and led_effect_sequencer

package les_pkg;

  localparam int MAX_LEDS = 8;

  localparam int FX_W    = 3;
  localparam int DUR_W   = 16;
  localparam int PHASE_W = 8;
  localparam int MASK_W  = 8;
  localparam int GSIZE_W = 4;

  typedef enum logic [FX_W-1:0] {
    FX_OFF        = 3'd0,
    FX_ON         = 3'd1,
    FX_BLINK      = 3'd2,
    FX_BLINK_FAST = 3'd3,
    FX_FLASH      = 3'd4,
    FX_FLASH_LONG = 3'd5,
    FX_SCAN_LOOP  = 3'd6,
    FX_SCAN_ONCE  = 3'd7
  } fx_t;

  typedef struct packed {
    fx_t                effect;
    logic [DUR_W-1:0]   step_len;
    logic [DUR_W-1:0]   tick;
    logic [PHASE_W-1:0] phase;
  } les_state_t;

endpackage

// File: hw/rtl/les_if.sv
// les_in_if, les_out_if: valid/ready channels of the led effect sequencer
// depends on les_pkg for field widths

interface les_in_if;
  import les_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [FX_W-1:0]      effect;
  logic [DUR_W-1:0]     duration;

  modport source (output valid, mode, effect, duration, input ready);
  modport sink   (input valid, mode, effect, duration, output ready);
endinterface

interface les_out_if;
  import les_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MASK_W-1:0]    led_mask;
  logic [FX_W-1:0]      effect_now;

  modport source (output valid, led_mask, effect_now, input ready);
  modport sink   (input valid, led_mask, effect_now, output ready);
endinterface

// File: hw/rtl/led_effect_sequencer.sv
// led_effect_sequencer: top level, input register, effect state, result register
// depends on les_pkg, les_in_if/les_out_if and les_step
//
//  port       dir   handshake      carries
//  in_chan    in    valid/ready    mode, effect, duration
//  out_chan   out   valid/ready    led_mask, effect_now
//  cfg_*      in    write enable   group_size (4 bits)
//
// one word per cycle unless an output stall holds the flow; a tick word's result passes the
// input register, then the result register, before it is valid; a command word gives none
// the throughput is set by the single pass through les_step between the two registers
// reset (rst_n low, synchronous) clears both registers, sets effect off, step 255,
// group size 1; an output stall holds the result and backs up into in_chan.ready

module led_effect_sequencer
  import les_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  les_in_if.sink              in_chan,
  les_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [GSIZE_W-1:0]  cfg_data
);

  logic                 in_vld_r;
  logic                 in_mode_r;
  logic [FX_W-1:0]      in_fx_r;
  logic [DUR_W-1:0]     in_dur_r;

  logic                 out_vld_r;
  logic [MASK_W-1:0]    out_mask_r;
  logic [FX_W-1:0]      out_fx_r;

  logic [GSIZE_W-1:0]   grp_size_r;
  les_state_t           st_r;
  les_state_t           st_tick;
  logic [MASK_W-1:0]    tick_mask;

  logic                 out_free;
  logic                 proc_fire;
  logic                 in_take;

  les_step u_step (
    .st       (st_r),
    .grp_size (grp_size_r),
    .st_nxt   (st_tick),
    .led_mask (tick_mask)
  );

  // commands need no output slot, ticks need the result register free
  assign out_free  = !out_vld_r || out_chan.ready;
  assign proc_fire = in_vld_r && (in_mode_r || out_free);
  assign in_take   = !in_vld_r || proc_fire;

  assign in_chan.ready       = in_take;
  assign out_chan.valid      = out_vld_r;
  assign out_chan.led_mask   = out_mask_r;
  assign out_chan.effect_now = out_fx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      grp_size_r  <= GSIZE_W'(1);
      st_r.effect   <= FX_OFF;
      st_r.step_len <= DUR_W'(255);
      st_r.tick     <= '0;
      st_r.phase    <= '0;
    end else begin
      if (cfg_we) begin
        grp_size_r <= cfg_data;
      end

      if (in_take) begin
        in_vld_r <= in_chan.valid;
      end

      if (proc_fire && !in_mode_r) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end

      if (proc_fire) begin
        if (in_mode_r) begin
          st_r.effect   <= fx_t'(in_fx_r);
          st_r.step_len <= in_dur_r;
          st_r.tick     <= '0;
          st_r.phase    <= '0;
        end else begin
          st_r <= st_tick;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take && in_chan.valid) begin
      in_mode_r <= in_chan.mode;
      in_fx_r   <= in_chan.effect;
      in_dur_r  <= in_chan.duration;
    end
    if (proc_fire && !in_mode_r) begin
      out_mask_r <= tick_mask;
      out_fx_r   <= st_tick.effect;
    end
  end

  a_rise_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(proc_fire && !in_mode_r))
    else $error("result appeared without a tick word");

  a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && in_mode_r && out_vld_r && !out_chan.ready) |=> out_vld_r && $stable(out_mask_r))
    else $error("command word disturbed a pending result");

  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.step_len >= DUR_W'(2)) |-> (st_r.tick < st_r.step_len))
    else $error("tick counter ran past the step length");

  a_flash_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && !in_mode_r && (st_r.effect == FX_FLASH || st_r.effect == FX_FLASH_LONG)
     && st_tick.tick == '0) |=> (out_fx_r == FX_OFF))
    else $error("flash did not turn off at step end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_chan.ready)
    else $error("input stalled with an empty input register");

endmodule

// File: hw/rtl/les_step.sv
// les_step: one tick of the effect engine, led mask and next state
// combinational; depends on les_pkg

module les_step
  import les_pkg::*;
(
  input  les_state_t          st,
  input  logic [GSIZE_W-1:0]  grp_size,
  output les_state_t          st_nxt,
  output logic [MASK_W-1:0]   led_mask
);

  logic [PHASE_W-1:0] n_leds;
  logic [PHASE_W-1:0] gs_ext;
  logic [PHASE_W-1:0] sweep_end;
  logic [PHASE_W-1:0] scan_pos;
  logic [PHASE_W-1:0] phase_base;
  logic [MASK_W-1:0]  all_mask;
  logic [MASK_W-1:0]  scan_mask;
  logic               step_end;
  logic               at_sweep_end;

  // clamp group size into 1..MAX_LEDS
  assign gs_ext = PHASE_W'(grp_size);
  always_comb begin
    if (gs_ext == '0) begin
      n_leds = PHASE_W'(1);
    end else if (gs_ext > PHASE_W'(MAX_LEDS)) begin
      n_leds = PHASE_W'(MAX_LEDS);
    end else begin
      n_leds = gs_ext;
    end
  end

  assign step_end = (st.step_len <= DUR_W'(1)) || (st.tick >= st.step_len - DUR_W'(1));

  assign sweep_end    = (n_leds << 1) - PHASE_W'(2);
  assign at_sweep_end = st.phase >= sweep_end;

  always_comb begin
    if (st.phase < n_leds) begin
      scan_pos = st.phase;
    end else if (st.phase <= sweep_end) begin
      scan_pos = sweep_end - st.phase;
    end else begin
      scan_pos = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      all_mask[i]  = PHASE_W'(i) < n_leds;
      scan_mask[i] = scan_pos == PHASE_W'(i);
    end
  end

  always_comb begin
    st_nxt     = st;
    led_mask   = '0;
    phase_base = st.phase;
    unique case (st.effect)
      FX_OFF: begin
        led_mask = '0;
      end
      FX_ON: begin
        led_mask = all_mask;
      end
      FX_BLINK, FX_BLINK_FAST: begin
        led_mask = st.phase[0] ? '0 : all_mask;
      end
      FX_FLASH, FX_FLASH_LONG: begin
        led_mask = all_mask;
        if (step_end) begin
          st_nxt.effect = FX_OFF;
        end
      end
      FX_SCAN_LOOP: begin
        led_mask = scan_mask;
        if (step_end && at_sweep_end) begin
          phase_base = '0;
        end
      end
      FX_SCAN_ONCE: begin
        led_mask = scan_mask;
        if (step_end && at_sweep_end) begin
          st_nxt.effect = FX_OFF;
        end
      end
      default: begin
        led_mask = '0;
      end
    endcase

    if (step_end) begin
      st_nxt.tick  = '0;
      st_nxt.phase = phase_base + PHASE_W'(1);
    end else begin
      st_nxt.tick  = st.tick + DUR_W'(1);
    end
  end

endmodule
